>>> hdl/chm_pkg.sv
// Shared types and constants of the chained hash map.
// Used by the interfaces, the controller, the datapath and the remainder unit.
package chm_pkg;

  localparam int KEY_W   = 64;
  localparam int VAL_W   = 64;
  localparam int OPC_W   = 3;
  localparam int HDL_W   = 8;
  localparam int CNT_W   = 9;
  localparam int CFG_W   = 7;
  localparam int STAT_W  = 2;
  localparam int DIGIT_W = 8;
  localparam int STEPS   = KEY_W / DIGIT_W;
  localparam int STEP_W  = $clog2(STEPS);

  typedef enum logic [OPC_W-1:0] {
    OP_INSERT = 3'd0,
    OP_LOOKUP = 3'd1,
    OP_REMOVE = 3'd2,
    OP_FIRST  = 3'd3,
    OP_NEXT   = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_END       = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISP, S_REM, S_HEAD_RD, S_HEAD_CHK, S_CMP, S_CLR_USED,
    S_MISS, S_SCAN, S_LINK, S_FIRST, S_HCHK, S_HUSED, S_ITEM, S_FIN
  } state_e;

  typedef enum logic [4:0] {
    U_NOP, U_CLEAR, U_ACCEPT, U_HEAD_RD, U_HEAD_CHK, U_UPD, U_HIT, U_UNLINK,
    U_CLR_USED, U_STEP, U_STEP_END, U_FULL, U_SCAN_START, U_SCAN_NEXT, U_ALLOC,
    U_LINK, U_FIRST, U_USED_RD, U_NEXT, U_ITEM, U_LOAD_OUT
  } uop_e;

  typedef struct packed {
    uop_e uop;
  } cmd_t;

  typedef struct packed {
    logic [OPC_W-1:0] op;
    logic             clear_last;
    logic             rem_done;
    logic             head_none;
    logic             key_match;
    logic             next_none;
    logic             full;
    logic             free_found;
    logic             hdl_ok;
    logic             hdl_used;
    logic             ohead_none;
    logic             onext_none;
    logic             out_free;
  } stat_t;

endpackage

>>> hdl/chm_if.sv
// Handshake channels of the chained hash map: request, response and configuration.
// Depends on chm_pkg for field widths.
interface chm_req_if;
  logic                         valid;
  logic                         ready;
  logic [chm_pkg::OPC_W-1:0]    opcode;
  logic [chm_pkg::KEY_W-1:0]    key;
  logic [chm_pkg::VAL_W-1:0]    new_value;
  logic [chm_pkg::HDL_W-1:0]    handle;
  modport source (output valid, opcode, key, new_value, handle, input ready);
  modport sink   (input valid, opcode, key, new_value, handle, output ready);
endinterface

interface chm_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [chm_pkg::STAT_W-1:0]   status;
  logic [chm_pkg::VAL_W-1:0]    found_value;
  logic [chm_pkg::KEY_W-1:0]    found_key;
  logic [chm_pkg::HDL_W-1:0]    out_handle;
  logic [chm_pkg::CNT_W-1:0]    entry_count;
  modport source (output valid, status, found_value, found_key, out_handle, entry_count,
                  input ready);
  modport sink   (input valid, status, found_value, found_key, out_handle, entry_count,
                  output ready);
endinterface

interface chm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [chm_pkg::CFG_W-1:0]    data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> hdl/chained_hash_map.sv
// Chained hash map top level: sequencer and datapath.
// Depends on chm_pkg, chm_if, chm_ctrl, chm_dp.
//
// Usage: one request channel (opcode, key, new_value, handle), one response
// channel (status, found_value, found_key, out_handle, entry_count), one
// configuration channel carrying the bucket count, always ready.
// Operations run one at a time; a request is taken only while the block is
// idle. Per operation:
//   lookup, remove, update of a present key: the key modulo bucket-count
//     unit (8 key bits a cycle) runs first, then the chain entries are
//     visited, one a cycle;
//   insert of a new key: as above, plus a free-slot search (one use word
//     of up to 32 bits a cycle) and the allocate and link steps;
//   first and next: walk the insertion-order list, with no remainder step.
// After reset a clearing pass empties the bucket heads and use words; no
// request is taken meanwhile.
// The result is held in an output register; while the receiver stalls the
// next request is still taken and worked on, and its result waits until the
// previous transfer completes.
module chained_hash_map #(
  parameter int BUCKETS = 64,
  parameter int ENTRIES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  chm_req_if.sink    req_i,
  chm_rsp_if.source  rsp_o,
  chm_cfg_if.sink    cfg_i
);
  import chm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_i.ready = 1'b1;

  chm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  chm_dp #(
    .BUCKETS (BUCKETS),
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .req_opcode_i      (req_i.opcode),
    .req_key_i         (req_i.key),
    .req_new_value_i   (req_i.new_value),
    .req_handle_i      (req_i.handle),
    .cfg_valid_i       (cfg_i.valid),
    .cfg_data_i        (cfg_i.data),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_status_o      (rsp_o.status),
    .rsp_found_value_o (rsp_o.found_value),
    .rsp_found_key_o   (rsp_o.found_key),
    .rsp_out_handle_o  (rsp_o.out_handle),
    .rsp_entry_count_o (rsp_o.entry_count)
  );
endmodule

>>> hdl/chm_rem.sv
// Key modulo bucket count, eight key bits per cycle.
// Depends on chm_pkg.
module chm_rem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [chm_pkg::KEY_W-1:0] key_i,
  input  logic [chm_pkg::CFG_W-1:0] div_i,
  output logic                      done_o,
  output logic [chm_pkg::CFG_W-1:0] rem_o
);
  import chm_pkg::*;

  logic                busy_q, busy_d, done_q, done_d;
  logic [STEP_W-1:0]   cnt_q, cnt_d;
  logic [KEY_W-1:0]    sh_q, sh_d;
  logic [CFG_W-1:0]    r_q, r_d, div_q, div_d, r_step;

  always_comb begin
    logic [CFG_W:0] t;
    logic [CFG_W-1:0] r;
    r = r_q;
    for (int i = 0; i < DIGIT_W; i++) begin
      t = {r, sh_q[KEY_W-1-i]};
      if (t >= {1'b0, div_q}) t = t - {1'b0, div_q};
      r = t[CFG_W-1:0];
    end
    r_step = r;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    r_d    = r_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      sh_d   = key_i;
      r_d    = '0;
      div_d  = div_i;
    end else if (busy_q) begin
      r_d   = r_step;
      sh_d  = sh_q << DIGIT_W;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == STEP_W'(STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    r_q   <= r_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = r_q;
endmodule

>>> hdl/chm_ctrl.sv
// Operation sequencer of the chained hash map.
// Depends on chm_pkg; drives micro-operations into chm_dp.
module chm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  chm_pkg::stat_t stat_i,
  output chm_pkg::cmd_t  cmd_o
);
  import chm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o.uop   = U_NOP;
    req_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.uop = U_CLEAR;
        if (stat_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.uop = U_ACCEPT;
          state_d   = S_DISP;
        end
      end
      S_DISP: begin
        if (stat_i.op == OP_INSERT || stat_i.op == OP_LOOKUP || stat_i.op == OP_REMOVE)
          state_d = S_REM;
        else if (stat_i.op == OP_FIRST) state_d = S_FIRST;
        else if (stat_i.op == OP_NEXT) state_d = S_HCHK;
        else state_d = S_FIN;
      end
      S_REM: begin
        if (stat_i.rem_done) state_d = S_HEAD_RD;
      end
      S_HEAD_RD: begin
        cmd_o.uop = U_HEAD_RD;
        state_d   = S_HEAD_CHK;
      end
      S_HEAD_CHK: begin
        cmd_o.uop = U_HEAD_CHK;
        state_d   = stat_i.head_none ? S_MISS : S_CMP;
      end
      S_CMP: begin
        if (stat_i.key_match) begin
          if (stat_i.op == OP_INSERT) begin
            cmd_o.uop = U_UPD;
            state_d   = S_FIN;
          end else if (stat_i.op == OP_LOOKUP) begin
            cmd_o.uop = U_HIT;
            state_d   = S_FIN;
          end else begin
            cmd_o.uop = U_UNLINK;
            state_d   = S_CLR_USED;
          end
        end else if (stat_i.next_none) begin
          cmd_o.uop = U_STEP_END;
          state_d   = S_MISS;
        end else begin
          cmd_o.uop = U_STEP;
        end
      end
      S_CLR_USED: begin
        cmd_o.uop = U_CLR_USED;
        state_d   = S_FIN;
      end
      S_MISS: begin
        if (stat_i.op == OP_INSERT) begin
          if (stat_i.full) begin
            cmd_o.uop = U_FULL;
            state_d   = S_FIN;
          end else begin
            cmd_o.uop = U_SCAN_START;
            state_d   = S_SCAN;
          end
        end else begin
          state_d = S_FIN;
        end
      end
      S_SCAN: begin
        if (stat_i.free_found) begin
          cmd_o.uop = U_ALLOC;
          state_d   = S_LINK;
        end else begin
          cmd_o.uop = U_SCAN_NEXT;
        end
      end
      S_LINK: begin
        cmd_o.uop = U_LINK;
        state_d   = S_FIN;
      end
      S_FIRST: begin
        cmd_o.uop = U_FIRST;
        state_d   = stat_i.ohead_none ? S_FIN : S_ITEM;
      end
      S_HCHK: begin
        if (stat_i.hdl_ok) begin
          cmd_o.uop = U_USED_RD;
          state_d   = S_HUSED;
        end else begin
          state_d = S_FIN;
        end
      end
      S_HUSED: begin
        if (stat_i.hdl_used) begin
          cmd_o.uop = U_NEXT;
          state_d   = stat_i.onext_none ? S_FIN : S_ITEM;
        end else begin
          state_d = S_FIN;
        end
      end
      S_ITEM: begin
        cmd_o.uop = U_ITEM;
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.uop = U_LOAD_OUT;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end
endmodule

>>> hdl/chm_dp.sv
// Datapath of the chained hash map: bucket heads, entry pool, link lists,
// slot-use words, remainder unit and output register. Depends on chm_pkg, chm_rem.
module chm_dp #(
  parameter int BUCKETS = 64,
  parameter int ENTRIES = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  chm_pkg::cmd_t              cmd_i,
  output chm_pkg::stat_t             stat_o,
  input  logic [chm_pkg::OPC_W-1:0]  req_opcode_i,
  input  logic [chm_pkg::KEY_W-1:0]  req_key_i,
  input  logic [chm_pkg::VAL_W-1:0]  req_new_value_i,
  input  logic [chm_pkg::HDL_W-1:0]  req_handle_i,
  input  logic                       cfg_valid_i,
  input  logic [chm_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                       rsp_ready_i,
  output logic                       rsp_valid_o,
  output logic [chm_pkg::STAT_W-1:0] rsp_status_o,
  output logic [chm_pkg::VAL_W-1:0]  rsp_found_value_o,
  output logic [chm_pkg::KEY_W-1:0]  rsp_found_key_o,
  output logic [chm_pkg::HDL_W-1:0]  rsp_out_handle_o,
  output logic [chm_pkg::CNT_W-1:0]  rsp_entry_count_o
);
  import chm_pkg::*;

  localparam int SW    = $clog2(ENTRIES);
  localparam int PW    = SW + 1;
  localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int UW    = (ENTRIES < 32) ? ENTRIES : 32;
  localparam int UB    = $clog2(UW);
  localparam int WORDS = (ENTRIES + UW - 1) / UW;
  localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CW    = $clog2(ENTRIES + 1);
  localparam int CLR_N = (BUCKETS > WORDS) ? BUCKETS : WORDS;
  localparam int KW    = (CLR_N > 1) ? $clog2(CLR_N) : 1;
  localparam logic [PW-1:0] NONE = {1'b1, {SW{1'b0}}};

  // memories
  logic [PW-1:0]    head_mem  [BUCKETS];
  logic [KEY_W-1:0] key_mem   [ENTRIES];
  logic [VAL_W-1:0] val_mem   [ENTRIES];
  logic [PW-1:0]    cnext_mem [ENTRIES];
  logic [PW-1:0]    cprev_mem [ENTRIES];
  logic [PW-1:0]    onext_mem [ENTRIES];
  logic [PW-1:0]    oprev_mem [ENTRIES];
  logic [UW-1:0]    used_mem  [WORDS];

  logic [PW-1:0]    head_rd_q, cnext_rd_q, cprev_rd_q, onext_rd_q, oprev_rd_q;
  logic [KEY_W-1:0] key_rd_q;
  logic [VAL_W-1:0] val_rd_q;
  logic [UW-1:0]    used_rd_q;

  logic             head_we, kv_we, key_we, cnext_we, cprev_we, onext_we, oprev_we, used_we;
  logic [BW-1:0]    head_ra, head_wa;
  logic [PW-1:0]    head_wd, cnext_wd, cprev_wd, onext_wd, oprev_wd;
  logic [SW-1:0]    slot_ra, kv_wa, cnext_wa, cprev_wa, onext_wa, oprev_wa;
  logic [WW-1:0]    used_ra, used_wa;
  logic [UW-1:0]    used_wd;

  // registers
  logic [OPC_W-1:0] op_q, op_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic [HDL_W-1:0] hdl_q, hdl_d;
  logic [BW-1:0]    bkt_q, bkt_d;
  logic [PW-1:0]    cur_q, cur_d, prv_q, prv_d;
  logic [SW-1:0]    new_q, new_d;
  logic [WW-1:0]    w_q, w_d;
  logic [KW-1:0]    clr_q, clr_d;
  logic [PW-1:0]    ohead_q, ohead_d, otail_q, otail_d;
  logic [CW-1:0]    live_q, live_d;
  logic [CFG_W-1:0] cfg_q, cfg_d;
  status_e          res_st_q, res_st_d;
  logic [VAL_W-1:0] res_val_q, res_val_d;
  logic [KEY_W-1:0] res_key_q, res_key_d;
  logic [HDL_W-1:0] res_oh_q, res_oh_d;
  logic             out_valid_q, out_valid_d;
  logic [STAT_W-1:0] out_st_q;
  logic [VAL_W-1:0] out_val_q;
  logic [KEY_W-1:0] out_key_q;
  logic [HDL_W-1:0] out_oh_q;
  logic [CNT_W-1:0] out_cnt_q;

  logic             rem_done;
  logic [CFG_W-1:0] rem, n_eff;
  logic [SW-1:0]    cur_slot, hslot, free_slot;
  logic [UB-1:0]    free_idx;
  logic             free_found;

  assign cur_slot = cur_q[SW-1:0];
  assign hslot    = SW'(hdl_q);

  always_comb begin
    if (cfg_q == '0) n_eff = CFG_W'(1);
    else if (32'(cfg_q) > BUCKETS) n_eff = CFG_W'(BUCKETS);
    else n_eff = cfg_q;
  end

  chm_rem u_rem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.uop == U_ACCEPT),
    .key_i   (req_key_i),
    .div_i   (n_eff),
    .done_o  (rem_done),
    .rem_o   (rem)
  );

  // lowest free slot within the word just read
  always_comb begin
    logic [WW+UB-1:0] pos;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = UW - 1; i >= 0; i--) begin
      pos = {w_q, UB'(i)};
      if ((32'(pos) < ENTRIES) && !used_rd_q[i]) begin
        free_found = 1'b1;
        free_idx   = UB'(i);
      end
    end
  end
  assign free_slot = SW'({w_q, free_idx});

  always_comb begin
    op_d = op_q; key_d = key_q; val_d = val_q; hdl_d = hdl_q;
    bkt_d = bkt_q; cur_d = cur_q; prv_d = prv_q; new_d = new_q; w_d = w_q;
    clr_d = clr_q; ohead_d = ohead_q; otail_d = otail_q; live_d = live_q;
    res_st_d = res_st_q; res_val_d = res_val_q; res_key_d = res_key_q; res_oh_d = res_oh_q;
    head_we = 1'b0; head_wa = bkt_q; head_wd = NONE; head_ra = bkt_q;
    kv_we = 1'b0; key_we = 1'b0; kv_wa = cur_slot;
    cnext_we = 1'b0; cnext_wa = cur_slot; cnext_wd = NONE;
    cprev_we = 1'b0; cprev_wa = cur_slot; cprev_wd = NONE;
    onext_we = 1'b0; onext_wa = cur_slot; onext_wd = NONE;
    oprev_we = 1'b0; oprev_wa = cur_slot; oprev_wd = NONE;
    used_we = 1'b0; used_wa = w_q; used_wd = used_rd_q; used_ra = w_q;
    slot_ra = cur_slot;
    case (cmd_i.uop)
      U_CLEAR: begin
        head_we = 32'(clr_q) < BUCKETS;
        head_wa = BW'(clr_q);
        used_we = 32'(clr_q) < WORDS;
        used_wa = WW'(clr_q);
        used_wd = '0;
        clr_d   = clr_q + 1'b1;
      end
      U_ACCEPT: begin
        op_d = req_opcode_i; key_d = req_key_i; val_d = req_new_value_i; hdl_d = req_handle_i;
        res_st_d = ST_NOT_FOUND; res_val_d = '0; res_key_d = '0; res_oh_d = '0;
      end
      U_HEAD_RD: begin
        bkt_d   = BW'(rem);
        head_ra = BW'(rem);
      end
      U_HEAD_CHK: begin
        cur_d   = head_rd_q;
        prv_d   = NONE;
        slot_ra = head_rd_q[SW-1:0];
      end
      U_UPD: begin
        kv_we    = 1'b1;
        res_st_d = ST_OK;
        res_oh_d = HDL_W'(cur_slot);
      end
      U_HIT: begin
        res_st_d  = ST_OK;
        res_val_d = val_rd_q;
        res_oh_d  = HDL_W'(cur_slot);
      end
      U_UNLINK: begin
        res_st_d  = ST_OK;
        res_val_d = val_rd_q;
        res_oh_d  = HDL_W'(cur_slot);
        if (!cprev_rd_q[SW]) begin
          cnext_we = 1'b1; cnext_wa = cprev_rd_q[SW-1:0]; cnext_wd = cnext_rd_q;
        end else begin
          head_we = 1'b1; head_wd = cnext_rd_q;
        end
        if (!cnext_rd_q[SW]) begin
          cprev_we = 1'b1; cprev_wa = cnext_rd_q[SW-1:0]; cprev_wd = cprev_rd_q;
        end
        if (!oprev_rd_q[SW]) begin
          onext_we = 1'b1; onext_wa = oprev_rd_q[SW-1:0]; onext_wd = onext_rd_q;
        end else begin
          ohead_d = onext_rd_q;
        end
        if (!onext_rd_q[SW]) begin
          oprev_we = 1'b1; oprev_wa = onext_rd_q[SW-1:0]; oprev_wd = oprev_rd_q;
        end else begin
          otail_d = oprev_rd_q;
        end
        used_ra = WW'(cur_slot >> UB);
      end
      U_CLR_USED: begin
        used_we = 1'b1;
        used_wa = WW'(cur_slot >> UB);
        used_wd = used_rd_q & ~(UW'(1) << cur_slot[UB-1:0]);
        live_d  = live_q - 1'b1;
      end
      U_STEP_END: begin
        prv_d = cur_q;
      end
      U_STEP: begin
        prv_d   = cur_q;
        cur_d   = cnext_rd_q;
        slot_ra = cnext_rd_q[SW-1:0];
      end
      U_FULL: begin
        res_st_d = ST_FULL;
      end
      U_SCAN_START: begin
        w_d     = '0;
        used_ra = '0;
      end
      U_SCAN_NEXT: begin
        w_d     = w_q + 1'b1;
        used_ra = w_q + 1'b1;
      end
      U_ALLOC: begin
        used_we  = 1'b1;
        used_wd  = used_rd_q | (UW'(1) << free_idx);
        kv_we    = 1'b1; key_we = 1'b1; kv_wa = free_slot;
        cnext_we = 1'b1; cnext_wa = free_slot; cnext_wd = NONE;
        cprev_we = 1'b1; cprev_wa = free_slot; cprev_wd = prv_q;
        onext_we = 1'b1; onext_wa = free_slot; onext_wd = NONE;
        oprev_we = 1'b1; oprev_wa = free_slot; oprev_wd = otail_q;
        if (prv_q[SW]) begin
          head_we = 1'b1; head_wd = {1'b0, free_slot};
        end
        new_d    = free_slot;
        res_st_d = ST_OK;
        res_oh_d = HDL_W'(free_slot);
      end
      U_LINK: begin
        if (!prv_q[SW]) begin
          cnext_we = 1'b1; cnext_wa = prv_q[SW-1:0]; cnext_wd = {1'b0, new_q};
        end
        if (!otail_q[SW]) begin
          onext_we = 1'b1; onext_wa = otail_q[SW-1:0]; onext_wd = {1'b0, new_q};
        end else begin
          ohead_d = {1'b0, new_q};
        end
        otail_d = {1'b0, new_q};
        live_d  = live_q + 1'b1;
      end
      U_FIRST: begin
        cur_d   = ohead_q;
        slot_ra = ohead_q[SW-1:0];
        if (ohead_q[SW]) res_st_d = ST_END;
      end
      U_USED_RD: begin
        used_ra = WW'(hslot >> UB);
        slot_ra = hslot;
      end
      U_NEXT: begin
        cur_d   = onext_rd_q;
        slot_ra = onext_rd_q[SW-1:0];
        if (onext_rd_q[SW]) res_st_d = ST_END;
      end
      U_ITEM: begin
        res_st_d  = ST_OK;
        res_val_d = val_rd_q;
        res_key_d = key_rd_q;
        res_oh_d  = HDL_W'(cur_slot);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_q <= head_mem[head_ra];
  end

  always_ff @(posedge clk_i) begin
    if (kv_we && key_we) key_mem[kv_wa] <= key_q;
    key_rd_q <= key_mem[slot_ra];
  end

  always_ff @(posedge clk_i) begin
    if (kv_we) val_mem[kv_wa] <= val_q;
    val_rd_q <= val_mem[slot_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cnext_we) cnext_mem[cnext_wa] <= cnext_wd;
    cnext_rd_q <= cnext_mem[slot_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cprev_we) cprev_mem[cprev_wa] <= cprev_wd;
    cprev_rd_q <= cprev_mem[slot_ra];
  end

  always_ff @(posedge clk_i) begin
    if (onext_we) onext_mem[onext_wa] <= onext_wd;
    onext_rd_q <= onext_mem[slot_ra];
  end

  always_ff @(posedge clk_i) begin
    if (oprev_we) oprev_mem[oprev_wa] <= oprev_wd;
    oprev_rd_q <= oprev_mem[slot_ra];
  end

  always_ff @(posedge clk_i) begin
    if (used_we) used_mem[used_wa] <= used_wd;
    used_rd_q <= used_mem[used_ra];
  end

  assign cfg_d       = cfg_valid_i ? cfg_data_i : cfg_q;
  assign out_valid_d = (cmd_i.uop == U_LOAD_OUT) || (out_valid_q && !rsp_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      ohead_q     <= NONE;
      otail_q     <= NONE;
      live_q      <= '0;
      cfg_q       <= CFG_W'(64);
      out_valid_q <= 1'b0;
    end else begin
      clr_q       <= clr_d;
      ohead_q     <= ohead_d;
      otail_q     <= otail_d;
      live_q      <= live_d;
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; key_q <= key_d; val_q <= val_d; hdl_q <= hdl_d;
    bkt_q <= bkt_d; cur_q <= cur_d; prv_q <= prv_d; new_q <= new_d; w_q <= w_d;
    res_st_q <= res_st_d; res_val_q <= res_val_d; res_key_q <= res_key_d;
    res_oh_q <= res_oh_d;
    if (cmd_i.uop == U_LOAD_OUT) begin
      out_st_q  <= res_st_q;
      out_val_q <= res_val_q;
      out_key_q <= res_key_q;
      out_oh_q  <= res_oh_q;
      out_cnt_q <= CNT_W'(live_q);
    end
  end

  always_comb begin
    stat_o.op         = op_q;
    stat_o.clear_last = clr_q == KW'(CLR_N - 1);
    stat_o.rem_done   = rem_done;
    stat_o.head_none  = head_rd_q[SW];
    stat_o.key_match  = key_rd_q == key_q;
    stat_o.next_none  = cnext_rd_q[SW];
    stat_o.full       = live_q == CW'(ENTRIES);
    stat_o.free_found = free_found;
    stat_o.hdl_ok     = 32'(hdl_q) < ENTRIES;
    stat_o.hdl_used   = used_rd_q[hslot[UB-1:0]];
    stat_o.ohead_none = ohead_q[SW];
    stat_o.onext_none = onext_rd_q[SW];
    stat_o.out_free   = !out_valid_q || rsp_ready_i;
  end

  assign rsp_valid_o       = out_valid_q;
  assign rsp_status_o      = out_st_q;
  assign rsp_found_value_o = out_val_q;
  assign rsp_found_key_o   = out_key_q;
  assign rsp_out_handle_o  = out_oh_q;
  assign rsp_entry_count_o = out_cnt_q;
endmodule
